// ===== sv/mwm_pkg.sv =====
// Package for the mecanum wheel mixer: fixed-point widths, pipeline stage map
// and the per-stage payload struct. No dependencies.
package mwm_pkg;

   localparam int CmdW   = 16;               // command width, signed
   localparam int Frac   = 14;               // fraction bits of commands
   localparam int M2W    = 2 * CmdW;         // squared magnitude width
   localparam int DvW    = CmdW + Frac;      // unit-scaling dividend width
   localparam int WhW    = CmdW + Frac + 3;  // wheel speed magnitude width
   localparam int RwW    = WhW + Frac + 1;   // wheel divider remainder width
   localparam int PW     = Frac + 8;         // n * pct
   localparam int UW     = 15;               // n * pct * 255 / 2^Frac (<= 25500)
   localparam int DutyW  = 8;
   localparam int PctW   = 7;
   localparam int GeoW   = 16;
   localparam int CsrAw  = 2;
   localparam int RootSteps = CmdW;          // one root bit per stage
   localparam int DivSteps  = Frac + 1;      // quotient bits Frac..0

   // reciprocal of 100: exact floor for every value below 2^UW
   localparam int RecipK  = 41944;
   localparam int RecipSh = 22;

   localparam logic [PctW-1:0] PctMax   = PctW'(100);
   localparam logic [PctW-1:0] PctReset = PctW'(100);
   localparam logic [GeoW-1:0] GeoReset = GeoW'(4096);
   localparam logic [M2W-1:0]  UnitSq   = M2W'(1) << (2 * Frac);
   localparam logic [WhW-1:0]  UnitT    = WhW'(1) << (2 * Frac + 1);

   // register indexes
   localparam logic [CsrAw-1:0] RegSpeedLimit = 2'd0;
   localparam logic [CsrAw-1:0] RegWidth      = 2'd1;
   localparam logic [CsrAw-1:0] RegLength     = 2'd2;

   // stage map
   localparam int StIn   = 0;
   localparam int StSq   = 1;
   localparam int StM2   = 2;
   localparam int StRt0  = 3;
   localparam int StDv0  = StRt0 + RootSteps;
   localparam int StVel  = StDv0 + DivSteps;
   localparam int StSum  = StVel + 1;
   localparam int StWhl  = StSum + 1;
   localparam int StMag  = StWhl + 1;
   localparam int StMx   = StMag + 1;
   localparam int StD    = StMx + 1;
   localparam int StFd0  = StD + 1;
   localparam int StP    = StFd0 + DivSteps;
   localparam int StU    = StP + 1;
   localparam int StOut  = StU + 1;
   localparam int NumSt  = StOut + 1;

   typedef struct packed {
      logic signed [CmdW-1:0]   x;
      logic signed [CmdW-1:0]   y;
      logic signed [CmdW-1:0]   w;
      logic [M2W-1:0]           sqx;
      logic [M2W-1:0]           sqy;
      logic [M2W-1:0]           n;
      logic [M2W-1:0]           r;
      logic                     big;
      logic [DvW-1:0]           remx;
      logic [DvW-1:0]           remy;
      logic [Frac:0]            qx;
      logic [Frac:0]            qy;
      logic signed [CmdW:0]     vx;
      logic signed [CmdW:0]     vy;
      logic signed [CmdW+1:0]   sumv;
      logic signed [CmdW+1:0]   difv;
      logic signed [WhW:0]      rot;
      logic [3:0][WhW:0]        v;
      logic [3:0][WhW-1:0]      av;
      logic [3:0]               neg;
      logic [WhW-1:0]           mxa;
      logic [WhW-1:0]           mxb;
      logic [WhW-1:0]           d;
      logic [3:0][RwW-1:0]      rw;
      logic [3:0][Frac:0]       nq;
      logic [3:0][PW-1:0]       p;
      logic [3:0][UW-1:0]       u;
      logic [3:0][DutyW-1:0]    fwd;
      logic [3:0][DutyW-1:0]    bwd;
   } pipe_type;

endpackage

// ===== sv/mecanum_wheel_mixer.sv =====
// Mecanum wheel mixer top level: a pipelined fixed-point datapath with
// integer root, unit scaling and wheel normalization. Depends on mwm_pkg.

// One command word (strafe, forward, turn, signed Q1.14) in, one word of
// eight wheel duties out. The datapath is a 58-stage pipeline: an item can
// enter every cycle while the output side does not stall. Most of the depth
// comes from the bit-per-stage integer square root (16 stages) and the two
// bit-per-stage dividers (15 stages each, unit scaling of the command and
// wheel normalization). Each stage holds its word while the stage after it
// is full and stalled, so bubbles close up and nothing is dropped.
// Registers: speed limit percent (low 7 bits of the write; values above 100
// saturate), track width and wheel base (unsigned Q2.14); write them only
// while the pipeline is empty.
module mecanum_wheel_mixer
   import mwm_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   // strafe_cmd [15:0], forward_cmd [31:16], turn_cmd [47:32]
   input  logic [47:0]      req_tdata,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // front_left_fwd_duty, front_left_bwd_duty, front_right_fwd_duty,
   // front_right_bwd_duty, rear_left_fwd_duty, rear_left_bwd_duty,
   // rear_right_fwd_duty, rear_right_bwd_duty; 8 bits each from bit 0 up
   output logic [63:0]      rsp_tdata,
   input  logic             csr_we,
   input  logic [CsrAw-1:0] csr_addr,
   input  logic [15:0]      csr_wdata
);

   logic [PctW-1:0] pct_ff, pct_in;
   logic [GeoW-1:0] width_ff, width_in;
   logic [GeoW-1:0] length_ff, length_in;
   logic [GeoW:0]   geo_sum;

   logic [NumSt-1:0] vld_ff, vld_in;
   logic [NumSt-1:0] en;
   pipe_type         pipe_ff [NumSt];
   pipe_type         pipe_in [NumSt];
   pipe_type         req_word;

   // ---------------- configuration registers ----------------
   always_comb begin
      pct_in    = pct_ff;
      width_in  = width_ff;
      length_in = length_ff;
      if (csr_we) begin
         unique case (csr_addr)
            RegSpeedLimit: pct_in = (csr_wdata[PctW-1:0] > PctMax) ? PctMax
                                                                 : csr_wdata[PctW-1:0];
            RegWidth:      width_in  = csr_wdata[GeoW-1:0];
            RegLength:     length_in = csr_wdata[GeoW-1:0];
            default:       ;  // unused index, write dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pct_ff    <= PctReset;
         width_ff  <= GeoReset;
         length_ff <= GeoReset;
      end else begin
         pct_ff    <= pct_in;
         width_ff  <= width_in;
         length_ff <= length_in;
      end
   end

   assign geo_sum = {1'b0, length_ff} + {1'b0, width_ff};

   // ---------------- stage function ----------------
   function automatic pipe_type stage_next(input int k, input pipe_type s,
                                           input logic [GeoW:0] lw,
                                           input logic [PctW-1:0] pct);
      pipe_type o;
      logic [M2W-1:0]   b, t;
      logic [DvW:0]     trial;
      logic [RwW-1:0]   wtrial;
      logic [CmdW-1:0]  ax, ay;
      logic [2*UW:0]    prod;
      logic [PW+7:0]    p255;
      logic signed [WhW:0] sh;
      int               j;
      o = s;
      if (k == StSq) begin
         ax = s.x[CmdW-1] ? CmdW'(-s.x) : CmdW'(s.x);
         ay = s.y[CmdW-1] ? CmdW'(-s.y) : CmdW'(s.y);
         o.sqx = M2W'(ax) * M2W'(ax);
         o.sqy = M2W'(ay) * M2W'(ay);
      end else if (k == StM2) begin
         ax = s.x[CmdW-1] ? CmdW'(-s.x) : CmdW'(s.x);
         ay = s.y[CmdW-1] ? CmdW'(-s.y) : CmdW'(s.y);
         o.n    = s.sqx + s.sqy;
         o.r    = '0;
         o.big  = (s.sqx + s.sqy) > UnitSq;
         o.remx = DvW'(ax) << Frac;
         o.remy = DvW'(ay) << Frac;
         o.qx   = '0;
         o.qy   = '0;
      end else if (k >= StRt0 && k < StDv0) begin
         // one root bit per stage, bit = 4^j
         j = RootSteps - 1 - (k - StRt0);
         b = M2W'(1) << (2 * j);
         t = s.r + b;
         if (s.n >= t) begin
            o.n = s.n - t;
            o.r = (s.r >> 1) + b;
         end else begin
            o.r = s.r >> 1;
         end
      end else if (k >= StDv0 && k < StVel) begin
         // quotient bit j of |c| * 2^Frac / root
         j = DivSteps - 1 - (k - StDv0);
         trial = (DvW+1)'(s.r[CmdW-1:0]) << j;
         if ({1'b0, s.remx} >= trial) begin
            o.remx = s.remx - DvW'(trial);
            o.qx[j] = 1'b1;
         end
         if ({1'b0, s.remy} >= trial) begin
            o.remy = s.remy - DvW'(trial);
            o.qy[j] = 1'b1;
         end
      end else if (k == StVel) begin
         if (s.big) begin
            o.vx = s.x[CmdW-1] ? -$signed({2'b00, s.qx}) : $signed({2'b00, s.qx});
            o.vy = s.y[CmdW-1] ? -$signed({2'b00, s.qy}) : $signed({2'b00, s.qy});
         end else begin
            o.vx = (CmdW+1)'(s.x);
            o.vy = (CmdW+1)'(s.y);
         end
         o.rot = (WhW+1)'(s.w) * $signed((WhW+1)'(lw));
      end else if (k == StSum) begin
         o.sumv = (CmdW+2)'(s.vy) + (CmdW+2)'(s.vx);
         o.difv = (CmdW+2)'(s.vy) - (CmdW+2)'(s.vx);
      end else if (k == StWhl) begin
         sh = (WhW+1)'(s.sumv) <<< (Frac + 1);
         o.v[0] = sh - s.rot;
         o.v[3] = sh + s.rot;
         sh = (WhW+1)'(s.difv) <<< (Frac + 1);
         o.v[1] = sh + s.rot;
         o.v[2] = sh - s.rot;
      end else if (k == StMag) begin
         for (int i = 0; i < 4; i++) begin
            o.neg[i] = s.v[i][WhW];
            o.av[i]  = s.v[i][WhW] ? WhW'(-$signed(s.v[i])) : s.v[i][WhW-1:0];
         end
      end else if (k == StMx) begin
         o.mxa = (s.av[0] > s.av[1]) ? s.av[0] : s.av[1];
         o.mxb = (s.av[2] > s.av[3]) ? s.av[2] : s.av[3];
      end else if (k == StD) begin
         if (s.mxa >= s.mxb) o.d = (s.mxa > UnitT) ? s.mxa : UnitT;
         else                o.d = (s.mxb > UnitT) ? s.mxb : UnitT;
         for (int i = 0; i < 4; i++) begin
            o.rw[i] = RwW'(s.av[i]) << Frac;
            o.nq[i] = '0;
         end
      end else if (k >= StFd0 && k < StP) begin
         j = DivSteps - 1 - (k - StFd0);
         wtrial = RwW'(s.d) << j;
         for (int i = 0; i < 4; i++) begin
            if (s.rw[i] >= wtrial) begin
               o.rw[i]    = s.rw[i] - wtrial;
               o.nq[i][j] = 1'b1;
            end
         end
      end else if (k == StP) begin
         for (int i = 0; i < 4; i++)
            o.p[i] = PW'(s.nq[i]) * PW'(pct);
      end else if (k == StU) begin
         for (int i = 0; i < 4; i++) begin
            p255   = ((PW+8)'(s.p[i]) << 8) - (PW+8)'(s.p[i]);
            o.u[i] = UW'(p255 >> Frac);
         end
      end else if (k == StOut) begin
         for (int i = 0; i < 4; i++) begin
            prod = (2*UW+1)'(s.u[i]) * (2*UW+1)'(RecipK);
            if (s.neg[i]) begin
               o.fwd[i] = '0;
               o.bwd[i] = DutyW'(prod >> RecipSh);
            end else begin
               o.fwd[i] = DutyW'(prod >> RecipSh);
               o.bwd[i] = '0;
            end
         end
      end
      return o;
   endfunction

   // ---------------- pipeline ----------------
   always_comb begin
      req_word   = '0;
      req_word.x = req_tdata[CmdW-1:0];
      req_word.y = req_tdata[2*CmdW-1:CmdW];
      req_word.w = req_tdata[3*CmdW-1:2*CmdW];
   end

   // a stage loads when it is empty or its word moves on
   always_comb begin
      en[NumSt-1] = !vld_ff[NumSt-1] || rsp_tready;
      for (int k = NumSt - 2; k >= 0; k--)
         en[k] = !vld_ff[k] || en[k+1];
   end

   assign req_tready = en[0];

   always_comb begin
      vld_in[0] = en[0] ? req_tvalid : vld_ff[0];
      for (int k = 1; k < NumSt; k++)
         vld_in[k] = en[k] ? vld_ff[k-1] : vld_ff[k];
   end

   assign pipe_in[0] = req_word;

   for (genvar k = 1; k < NumSt; k++) begin : g_stage
      assign pipe_in[k] = stage_next(k, pipe_ff[k-1], geo_sum, pct_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else       vld_ff <= vld_in;
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < NumSt; k++)
         if (en[k]) pipe_ff[k] <= pipe_in[k];
   end

   assign rsp_tvalid = vld_ff[NumSt-1];
   assign rsp_tdata  = {pipe_ff[NumSt-1].bwd[3], pipe_ff[NumSt-1].fwd[3],
                        pipe_ff[NumSt-1].bwd[2], pipe_ff[NumSt-1].fwd[2],
                        pipe_ff[NumSt-1].bwd[1], pipe_ff[NumSt-1].fwd[1],
                        pipe_ff[NumSt-1].bwd[0], pipe_ff[NumSt-1].fwd[0]};

endmodule

// ===== bench/mwm_checker.sv =====
// Checker for the mecanum wheel mixer: watches both streams, predicts the
// eight duties of each accepted command and compares them. Depends on mwm_pkg.
module mwm_checker
   import mwm_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   input  logic             req_tready,
   input  logic [47:0]      req_tdata,
   input  logic             rsp_tvalid,
   input  logic             rsp_tready,
   input  logic [63:0]      rsp_tdata,
   input  logic             csr_we,
   input  logic [CsrAw-1:0] csr_addr,
   input  logic [15:0]      csr_wdata,
   output int               fail_count,
   output int               pending
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [63:0]  duty_queue[$];
   logic [6:0]   lim_pct;
   logic [15:0]  trk_w, base_l;
   string        duty_name[8] = '{"front_left_fwd_duty", "front_left_bwd_duty",
                                  "front_right_fwd_duty", "front_right_bwd_duty",
                                  "rear_left_fwd_duty", "rear_left_bwd_duty",
                                  "rear_right_fwd_duty", "rear_right_bwd_duty"};

   function automatic longint unsigned root_floor(longint unsigned n);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic longint absl(longint v);
      return v < 0 ? -v : v;
   endfunction

   function automatic logic [63:0] mix_duties(logic [47:0] cmd);
      longint x, y, w, vx, vy, rot, sum, dif, d, n, duty;
      longint v[4];
      longint unsigned m2, m;
      logic [63:0] r;
      x = longint'($signed(cmd[15:0]));
      y = longint'($signed(cmd[31:16]));
      w = longint'($signed(cmd[47:32]));
      vx = x; vy = y;
      m2 = x * x + y * y;
      if (m2 > (64'd1 << 28)) begin
         m = root_floor(m2);
         vx = (x < 0) ? -((absl(x) << 14) / m) : ((x << 14) / m);
         vy = (y < 0) ? -((absl(y) << 14) / m) : ((y << 14) / m);
      end
      rot = w * (longint'(base_l) + longint'(trk_w));
      sum = (vy + vx) * 32768;
      dif = (vy - vx) * 32768;
      v[0] = sum - rot; v[1] = dif + rot; v[2] = dif - rot; v[3] = sum + rot;
      d = 64'd1 << 29;
      foreach (v[i]) if (absl(v[i]) > d) d = absl(v[i]);
      r = '0;
      foreach (v[i]) begin
         // floor(|v|*S/d), capped at S since |v| <= d
         n = (absl(v[i]) >= d) ? 16384 : (absl(v[i]) * 16384) / d;
         duty = ((n * lim_pct * 255) / (100 * 16384)) & 255;
         if (v[i] >= 0) r[16*i +: 8] = duty[7:0];
         else r[16*i+8 +: 8] = duty[7:0];
      end
      return r;
   endfunction

   assign pending = duty_queue.size();

   always @(posedge clock) begin
      logic [63:0] exp_w;
      if (reset) begin
         lim_pct <= PctReset;
         trk_w <= GeoReset;
         base_l <= GeoReset;
         duty_queue.delete();
         fail_count <= 0;
      end else begin
         if (csr_we) begin
            case (csr_addr)
               RegSpeedLimit: lim_pct <= (csr_wdata[6:0] > PctMax) ? PctMax : csr_wdata[6:0];
               RegWidth:      trk_w <= csr_wdata;
               RegLength:     base_l <= csr_wdata;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) duty_queue.push_back(mix_duties(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            if (duty_queue.size() == 0) begin
               $error("unexpected word %h", rsp_tdata);
               fail_count <= fail_count + 1;
            end else begin
               exp_w = duty_queue.pop_front();
               if (exp_w != rsp_tdata) begin
                  for (int k = 0; k < 8; k++)
                     if (exp_w[8*k +: 8] != rsp_tdata[8*k +: 8])
                        $error("%s: expected %0d, got %0d", duty_name[k],
                           exp_w[8*k +: 8], rsp_tdata[8*k +: 8]);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule

// ===== bench/tb_mecanum_wheel_mixer.sv =====
// Top of the mixer bench: clock, reset, command and register stimulus,
// random stalls and verdict. Depends on mwm_pkg, mwm_checker and the DUT.
module tb_mecanum_wheel_mixer;
   import mwm_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PipeDrain = 80;     // 58-stage pipeline plus margin
   localparam int DogLimit  = 20000;  // idle cycles before giving up

   logic clock = 0, reset = 1;
   logic req_tvalid = 0, req_tready;
   logic [47:0] req_tdata = '0;
   logic rsp_tvalid, rsp_tready = 0;
   logic [63:0] rsp_tdata;
   logic csr_we = 0;
   logic [CsrAw-1:0] csr_addr = '0;
   logic [15:0] csr_wdata = '0;
   int fail_count, pending, quiet_cycles;
   bit calm;  // no idling on either side while set

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   mecanum_wheel_mixer DUT (.*);

   mwm_checker u_checker (.*);

   // sink side stalls ~23% unless in a calm stretch
   always @(posedge clock)
      rsp_tready <= calm || ($urandom_range(99) >= 23);

   // watchdog on accepted words
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= DogLimit) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // valid stays up between back-to-back words; idle cycles drop it
   task automatic send_word(logic signed [15:0] x, y, w);
      while (!calm && $urandom_range(99) < 23) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {w, y, x};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic drain;
      req_tvalid <= 0;
      while (pending != 0) @(posedge clock);
      repeat (PipeDrain) @(posedge clock);
   endtask

   task automatic write_reg(logic [CsrAw-1:0] idx, logic [15:0] val);
      csr_we <= 1;
      csr_addr <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 0;
      @(posedge clock);
   endtask

   function automatic logic [15:0] pick_cmd();
      case ($urandom_range(5))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'($signed($urandom_range(32768)) - 16384);  // within unit
         3: return 16'($urandom_range(3)) - 16'd1;
         default: return 16'($urandom);
      endcase
   endfunction

   initial begin
      logic signed [15:0] edge_vals[6] = '{16'sh8000, 16'sh7fff, 16'sh0000,
                                           16'sh4000, -16'sh4000, 16'sh0001};
      calm = 0;
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: extremes, unit-length vector, pure rotation, zero
      foreach (edge_vals[i]) send_word(edge_vals[i], 16'sh0000, 16'sh0000);
      send_word(16'sh0000, 16'sh4000, 16'sh0000);   // magnitude exactly one
      send_word(16'sh2d41, 16'sh2d41, 16'sh0000);   // diagonal near one
      send_word(16'sh0000, 16'sh0000, 16'sh4000);   // rotation only
      send_word(16'sh0000, 16'sh2000, 16'sh2000);   // forward with rotation
      send_word(16'sh7fff, 16'sh7fff, 16'sh7fff);
      send_word(16'sh8000, 16'sh8000, 16'sh8000);
      send_word(16'sh8000, 16'sh7fff, 16'shffff);
      send_word(16'sh1234, -16'sh0abc, 16'sh0777);
      drain();  // sender holds off until all results are in

      // register sweep: saturating limit, zero and max geometry
      write_reg(RegSpeedLimit, 16'd127);
      write_reg(RegWidth, 16'hffff);
      write_reg(RegLength, 16'hffff);
      write_reg(2'd3, 16'h0005);  // unmapped index, ignored
      send_word(16'sh0000, 16'sh0000, 16'sh7fff);
      send_word(16'sh7fff, 16'sh0100, 16'sh8000);

      for (int ph = 0; ph < 6; ph++) begin
         drain();
         case (ph)
            0: begin write_reg(RegSpeedLimit, 16'd0); write_reg(RegWidth, 16'd0);
                     write_reg(RegLength, 16'd0); end
            1: begin write_reg(RegSpeedLimit, 16'd1); write_reg(RegWidth, 16'd8192);
                     write_reg(RegLength, 16'd2048); end
            2: begin write_reg(RegSpeedLimit, 16'd100); write_reg(RegWidth, GeoReset);
                     write_reg(RegLength, GeoReset); end
            default: begin
               write_reg(RegSpeedLimit, 16'($urandom_range(127)));
               write_reg(RegWidth, 16'($urandom));
               write_reg(RegLength, 16'($urandom));
            end
         endcase
         calm = (ph == 3);  // one long stretch without idling
         repeat (200) send_word(pick_cmd(), pick_cmd(), pick_cmd());
         calm = 0;
      end

      drain();
      if (fail_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end
endmodule
